// ===== design/slnt_pkg.sv =====
package slnt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ACTION_W  = 3;
    localparam int KEY_W     = 16;
    localparam int PAYLOAD_W = 16;
    localparam int POS_W     = 8;
    localparam int STATUS_W  = 4;
    localparam int INDEX_W   = 8;
    localparam int ECOUNT_W  = 9;
    localparam int ENTRY_W   = KEY_W + PAYLOAD_W;
    localparam int CMP_W     = (CNT_W > POS_W) ? CNT_W : POS_W + 1;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    localparam logic [ACTION_W-1:0] ACT_ENTER  = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 4'd0;
    localparam logic [STATUS_W-1:0] ST_REPLACED  = 4'd1;
    localparam logic [STATUS_W-1:0] ST_DELETED   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 4'd3;
    localparam logic [STATUS_W-1:0] ST_READ      = 4'd4;
    localparam logic [STATUS_W-1:0] ST_CLEARED   = 4'd5;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 4'd6;
    localparam logic [STATUS_W-1:0] ST_RANGE     = 4'd7;
    localparam logic [STATUS_W-1:0] ST_FULL      = 4'd8;
    localparam logic [STATUS_W-1:0] ST_BAD_KEY   = 4'd9;

    typedef logic [IDX_W-1:0] addr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic [ACTION_W-1:0]  action;
        logic [KEY_W-1:0]     key;
        logic [PAYLOAD_W-1:0] payload;
        logic [POS_W-1:0]     position;
    } item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [INDEX_W-1:0]   index;
        logic [KEY_W-1:0]     key_out;
        logic [PAYLOAD_W-1:0] payload_out;
        logic [ECOUNT_W-1:0]  entry_count;
    } res_t;

    typedef struct packed {
        logic               rd_en;
        addr_t              rd_addr;
        logic               wr_en;
        addr_t              wr_addr;
        logic [ENTRY_W-1:0] wr_data;
    } mem_req_t;

endpackage

// ===== design/sorted_line_number_table_core.sv =====
// Sorted line-number table: (line number, text handle) entries kept in
// ascending key order in one 256 x 32 synchronous RAM.
// Input channel s_*: one item per action (enter, delete, find, read, clear).
// Output channel m_*: exactly one result item per input item, in order.
// Work per item, after acceptance:
//   clear, bad key, out of range: answered without a RAM access
//   read: one RAM read of the entry at the position
//   find, replace: a scan from entry 0 up to the key or the first larger key
//   enter new key: the scan, then a shift up by one of the entries from the end
//   of the table down to the insertion point, then a write of the new entry
//   delete at p: a shift down by one of the entries above p
// Both the scan and the shift move one RAM entry per cycle through the single
// read port and single write port; one item is worked on at a time.
// The output register holds a finished result while the next item is already
// taken; a stalled m_tready holds the result and, once the next result is done,
// holds off s_tready.
// Reset empties the table (entry count 0); the RAM contents are not cleared
// and need no clearing pass, since only entries below the count are read.
module sorted_line_number_table_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // action[2:0], key[18:3], payload[34:19], position[42:35]
    input  logic [slnt_pkg::IN_DATA_W-1:0]      s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status[3:0], index[11:4], key_out[27:12], payload_out[43:28],
    // entry_count[52:44]
    output logic [slnt_pkg::OUT_DATA_W-1:0]     m_tdata
);

    slnt_pkg::item_t                 in_item;
    slnt_pkg::res_t                  res;
    slnt_pkg::mem_req_t              mem_req;
    logic [slnt_pkg::ENTRY_W-1:0]    rd_data;
    logic                            res_valid;
    logic                            res_ready;
    logic                            m_valid_reg;
    slnt_pkg::res_t                  m_res_reg;

    assign in_item.action   = s_tdata[2:0];
    assign in_item.key      = s_tdata[18:3];
    assign in_item.payload  = s_tdata[34:19];
    assign in_item.position = s_tdata[42:35];

    slnt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    slnt_ram #(
        .WIDTH (slnt_pkg::ENTRY_W),
        .DEPTH (slnt_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (rd_data)
    );

    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {3'b000, m_res_reg.entry_count, m_res_reg.payload_out,
                       m_res_reg.key_out, m_res_reg.index, m_res_reg.status};

endmodule

// ===== design/slnt_ram.sv =====
module slnt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/slnt_ctrl.sv =====
module slnt_ctrl (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  slnt_pkg::item_t                     in_item,
    output logic                                res_valid,
    input  logic                                res_ready,
    output slnt_pkg::res_t                      res,
    output slnt_pkg::mem_req_t                  mem_req,
    input  logic [slnt_pkg::ENTRY_W-1:0]        rd_data
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SEARCH   = 3'd1;
    localparam logic [2:0] S_SHIFT_UP = 3'd2;
    localparam logic [2:0] S_SHIFT_DN = 3'd3;
    localparam logic [2:0] S_READ     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    localparam int CNT_W = slnt_pkg::CNT_W;
    localparam int IDX_W = slnt_pkg::IDX_W;
    localparam int KEY_W = slnt_pkg::KEY_W;
    localparam int PW    = slnt_pkg::PAYLOAD_W;

    logic [2:0]                      state_reg, state_next;
    slnt_pkg::cnt_t                  cnt_reg, cnt_next;
    slnt_pkg::cnt_t                  rd_ptr_reg, rd_ptr_next;
    slnt_pkg::cnt_t                  ins_reg, ins_next;
    logic                            cmp_vld_reg, cmp_vld_next;
    logic                            sh_vld_reg, sh_vld_next;
    slnt_pkg::addr_t                 cmp_ptr_reg, cmp_ptr_next;
    slnt_pkg::addr_t                 sh_dst_reg, sh_dst_next;
    logic [slnt_pkg::ACTION_W-1:0]   act_reg, act_next;
    logic [KEY_W-1:0]                key_reg, key_next;
    logic [PW-1:0]                   pay_reg, pay_next;
    slnt_pkg::cnt_t                  pos_reg, pos_next;
    slnt_pkg::res_t                  res_reg, res_next;

    logic [KEY_W-1:0] rkey;
    logic             pos_oor;

    assign rkey    = rd_data[slnt_pkg::ENTRY_W-1 -: KEY_W];
    assign pos_oor = slnt_pkg::CMP_W'(in_item.position) >= slnt_pkg::CMP_W'(cnt_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res       = res_reg;

    function automatic slnt_pkg::res_t mk_res(
        input logic [slnt_pkg::STATUS_W-1:0] st,
        input slnt_pkg::cnt_t                idx,
        input logic [KEY_W-1:0]              k,
        input logic [PW-1:0]                 p,
        input slnt_pkg::cnt_t                cnt
    );
        slnt_pkg::res_t r;
        r.status      = st;
        r.index       = slnt_pkg::INDEX_W'(idx);
        r.key_out     = k;
        r.payload_out = p;
        r.entry_count = slnt_pkg::ECOUNT_W'(cnt);
        return r;
    endfunction

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rd_ptr_next  = rd_ptr_reg;
        ins_next     = ins_reg;
        cmp_vld_next = cmp_vld_reg;
        sh_vld_next  = sh_vld_reg;
        cmp_ptr_next = cmp_ptr_reg;
        sh_dst_next  = sh_dst_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        pay_next     = pay_reg;
        pos_next     = pos_reg;
        res_next     = res_reg;
        mem_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    act_next     = in_item.action;
                    key_next     = in_item.key;
                    pay_next     = in_item.payload;
                    pos_next     = CNT_W'(in_item.position);
                    rd_ptr_next  = '0;
                    cmp_vld_next = 1'b0;
                    sh_vld_next  = 1'b0;
                    state_next   = S_DONE;
                    case (in_item.action)
                        slnt_pkg::ACT_ENTER:
                        begin
                            if (in_item.key == '0)
                            begin
                                res_next = mk_res(slnt_pkg::ST_BAD_KEY, '0, '0, '0, cnt_reg);
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        slnt_pkg::ACT_FIND:
                        begin
                            if (in_item.key == '0)
                            begin
                                res_next = mk_res(slnt_pkg::ST_NOT_FOUND, '0, '0, '0, cnt_reg);
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        slnt_pkg::ACT_DELETE:
                        begin
                            if (pos_oor)
                            begin
                                res_next = mk_res(slnt_pkg::ST_RANGE, '0, '0, '0, cnt_reg);
                            end
                            else
                            begin
                                rd_ptr_next = CNT_W'(in_item.position) + CNT_W'(1);
                                state_next  = S_SHIFT_DN;
                            end
                        end
                        slnt_pkg::ACT_READ:
                        begin
                            if (pos_oor)
                            begin
                                res_next = mk_res(slnt_pkg::ST_RANGE, '0, '0, '0, cnt_reg);
                            end
                            else
                            begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = IDX_W'(in_item.position);
                                state_next      = S_READ;
                            end
                        end
                        slnt_pkg::ACT_CLEAR:
                        begin
                            cnt_next = '0;
                            res_next = mk_res(slnt_pkg::ST_CLEARED, '0, '0, '0, '0);
                        end
                        default:
                        begin
                            res_next = mk_res(slnt_pkg::ST_RANGE, '0, '0, '0, cnt_reg);
                        end
                    endcase
                end
            end

            S_SEARCH:
            begin
                if (cmp_vld_reg && rkey == key_reg)
                begin
                    if (act_reg == slnt_pkg::ACT_ENTER)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = cmp_ptr_reg;
                        mem_req.wr_data = {key_reg, pay_reg};
                        res_next = mk_res(slnt_pkg::ST_REPLACED, CNT_W'(cmp_ptr_reg),
                                          '0, '0, cnt_reg);
                    end
                    else
                    begin
                        res_next = mk_res(slnt_pkg::ST_FOUND, CNT_W'(cmp_ptr_reg),
                                          '0, '0, cnt_reg);
                    end
                    state_next = S_DONE;
                end
                else if ((cmp_vld_reg && rkey > key_reg) ||
                         (!cmp_vld_reg && rd_ptr_reg >= cnt_reg))
                begin
                    // insertion point: first larger key, or end of table
                    ins_next = cmp_vld_reg ? CNT_W'(cmp_ptr_reg) : cnt_reg;
                    if (act_reg != slnt_pkg::ACT_ENTER)
                    begin
                        res_next   = mk_res(slnt_pkg::ST_NOT_FOUND, '0, '0, '0, cnt_reg);
                        state_next = S_DONE;
                    end
                    else if (cnt_reg >= CNT_W'(slnt_pkg::TABLE_DEPTH))
                    begin
                        res_next   = mk_res(slnt_pkg::ST_FULL, '0, '0, '0, cnt_reg);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rd_ptr_next = cnt_reg;
                        sh_vld_next = 1'b0;
                        state_next  = S_SHIFT_UP;
                    end
                end
                else if (rd_ptr_reg < cnt_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(rd_ptr_reg);
                    cmp_ptr_next    = IDX_W'(rd_ptr_reg);
                    cmp_vld_next    = 1'b1;
                    rd_ptr_next     = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    cmp_vld_next = 1'b0;
                end
            end

            S_SHIFT_UP:
            begin
                if (sh_vld_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = sh_dst_reg;
                    mem_req.wr_data = rd_data;
                end
                if (rd_ptr_reg > ins_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(rd_ptr_reg - CNT_W'(1));
                    sh_dst_next     = IDX_W'(rd_ptr_reg);
                    sh_vld_next     = 1'b1;
                    rd_ptr_next     = rd_ptr_reg - CNT_W'(1);
                end
                else
                begin
                    sh_vld_next = 1'b0;
                    if (!sh_vld_reg)
                    begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = IDX_W'(ins_reg);
                        mem_req.wr_data = {key_reg, pay_reg};
                        cnt_next   = cnt_reg + CNT_W'(1);
                        res_next   = mk_res(slnt_pkg::ST_INSERTED, ins_reg, '0, '0,
                                            cnt_reg + CNT_W'(1));
                        state_next = S_DONE;
                    end
                end
            end

            S_SHIFT_DN:
            begin
                if (sh_vld_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_addr = sh_dst_reg;
                    mem_req.wr_data = rd_data;
                end
                if (rd_ptr_reg < cnt_reg)
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = IDX_W'(rd_ptr_reg);
                    sh_dst_next     = IDX_W'(rd_ptr_reg - CNT_W'(1));
                    sh_vld_next     = 1'b1;
                    rd_ptr_next     = rd_ptr_reg + CNT_W'(1);
                end
                else
                begin
                    sh_vld_next = 1'b0;
                    if (!sh_vld_reg)
                    begin
                        cnt_next   = cnt_reg - CNT_W'(1);
                        res_next   = mk_res(slnt_pkg::ST_DELETED, pos_reg, '0, '0,
                                            cnt_reg - CNT_W'(1));
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                res_next   = mk_res(slnt_pkg::ST_READ, pos_reg, rkey, rd_data[PW-1:0], cnt_reg);
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            sh_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            cmp_vld_reg <= cmp_vld_next;
            sh_vld_reg  <= sh_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_ptr_reg  <= rd_ptr_next;
        ins_reg     <= ins_next;
        cmp_ptr_reg <= cmp_ptr_next;
        sh_dst_reg  <= sh_dst_next;
        act_reg     <= act_next;
        key_reg     <= key_next;
        pay_reg     <= pay_next;
        pos_reg     <= pos_next;
        res_reg     <= res_next;
    end

endmodule

// ===== bench/sorted_line_number_table_core_test.sv =====
`timescale 1ns / 1ps

module sorted_line_number_table_core_test;

    localparam int STALL_LIMIT = 5000;
    localparam int TAIL_CYCLES = 600;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [slnt_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [slnt_pkg::OUT_DATA_W-1:0] m_tdata;

    // shadow copy of the table
    logic [slnt_pkg::KEY_W-1:0]     tab_key [slnt_pkg::TABLE_DEPTH];
    logic [slnt_pkg::PAYLOAD_W-1:0] tab_pay [slnt_pkg::TABLE_DEPTH];
    int                             used = 0;

    slnt_pkg::res_t awaited_replies[$];
    int   error_count = 0;
    int   quiet_cycles = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;

    sorted_line_number_table_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic slnt_pkg::item_t make_item(logic [slnt_pkg::ACTION_W-1:0] act,
                                                  logic [slnt_pkg::KEY_W-1:0] k,
                                                  logic [slnt_pkg::PAYLOAD_W-1:0] p,
                                                  logic [slnt_pkg::POS_W-1:0] pos);
        slnt_pkg::item_t it;
        it.action   = act;
        it.key      = k;
        it.payload  = p;
        it.position = pos;
        return it;
    endfunction

    function automatic slnt_pkg::res_t apply_to_table(slnt_pkg::item_t it);
        slnt_pkg::res_t r;
        int   i;
        int   j;
        r = '0;
        case (it.action)
            slnt_pkg::ACT_ENTER:
            begin
                if (it.key == '0)
                begin
                    r.status = slnt_pkg::ST_BAD_KEY;
                end
                else
                begin
                    i = 0;
                    while (i < used && tab_key[i] < it.key)
                        i++;
                    if (i < used && tab_key[i] == it.key)
                    begin
                        tab_pay[i] = it.payload;
                        r.status   = slnt_pkg::ST_REPLACED;
                        r.index    = slnt_pkg::INDEX_W'(i);
                    end
                    else if (used >= slnt_pkg::TABLE_DEPTH)
                    begin
                        r.status = slnt_pkg::ST_FULL;
                    end
                    else
                    begin
                        for (j = used; j > i; j--)
                        begin
                            tab_key[j] = tab_key[j-1];
                            tab_pay[j] = tab_pay[j-1];
                        end
                        tab_key[i] = it.key;
                        tab_pay[i] = it.payload;
                        used++;
                        r.status = slnt_pkg::ST_INSERTED;
                        r.index  = slnt_pkg::INDEX_W'(i);
                    end
                end
            end
            slnt_pkg::ACT_DELETE:
            begin
                if (int'(it.position) >= used)
                begin
                    r.status = slnt_pkg::ST_RANGE;
                end
                else
                begin
                    used--;
                    for (i = int'(it.position); i < used; i++)
                    begin
                        tab_key[i] = tab_key[i+1];
                        tab_pay[i] = tab_pay[i+1];
                    end
                    r.status = slnt_pkg::ST_DELETED;
                    r.index  = it.position;
                end
            end
            slnt_pkg::ACT_FIND:
            begin
                r.status = slnt_pkg::ST_NOT_FOUND;
                if (it.key != '0)
                begin
                    for (i = 0; i < used; i++)
                    begin
                        if (tab_key[i] == it.key && r.status == slnt_pkg::ST_NOT_FOUND)
                        begin
                            r.status = slnt_pkg::ST_FOUND;
                            r.index  = slnt_pkg::INDEX_W'(i);
                        end
                    end
                end
            end
            slnt_pkg::ACT_READ:
            begin
                if (int'(it.position) >= used)
                begin
                    r.status = slnt_pkg::ST_RANGE;
                end
                else
                begin
                    r.status      = slnt_pkg::ST_READ;
                    r.index       = it.position;
                    r.key_out     = tab_key[it.position];
                    r.payload_out = tab_pay[it.position];
                end
            end
            slnt_pkg::ACT_CLEAR:
            begin
                used     = 0;
                r.status = slnt_pkg::ST_CLEARED;
            end
            default:
            begin
                r.status = slnt_pkg::ST_RANGE;
            end
        endcase
        r.entry_count = slnt_pkg::ECOUNT_W'(used);
        return r;
    endfunction

    function automatic logic [slnt_pkg::KEY_W-1:0] choose_key();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return '0;
        if (pick < 30 && used > 0)
            return tab_key[$urandom_range(used - 1)];
        if (pick < 45)
            return slnt_pkg::KEY_W'($urandom_range(64, 1));
        return slnt_pkg::KEY_W'($urandom_range(65535, 1));
    endfunction

    function automatic logic [slnt_pkg::POS_W-1:0] choose_position();
        if (used > 0 && $urandom_range(99) < 85)
            return slnt_pkg::POS_W'($urandom_range(used - 1));
        return slnt_pkg::POS_W'($urandom_range(255));
    endfunction

    function automatic logic [slnt_pkg::KEY_W-1:0] absent_key();
        logic [slnt_pkg::KEY_W-1:0] k;
        logic                       hit;
        int                         i;
        do
        begin
            k   = slnt_pkg::KEY_W'($urandom_range(65535, 1));
            hit = 1'b0;
            for (i = 0; i < used; i++)
                if (tab_key[i] == k)
                    hit = 1'b1;
        end
        while (hit);
        return k;
    endfunction

    function automatic slnt_pkg::item_t random_item();
        slnt_pkg::item_t it;
        int unsigned     pick;
        pick = $urandom_range(99);
        it = make_item(slnt_pkg::ACT_ENTER, slnt_pkg::KEY_W'($urandom_range(65535)),
                       slnt_pkg::PAYLOAD_W'($urandom_range(65535)),
                       slnt_pkg::POS_W'($urandom_range(255)));
        if (pick < 40)
        begin
            it.key = choose_key();
        end
        else if (pick < 55)
        begin
            it.action = slnt_pkg::ACT_FIND;
            if (used > 0 && $urandom_range(1) == 1)
                it.key = tab_key[$urandom_range(used - 1)];
            else
                it.key = choose_key();
        end
        else if (pick < 70)
        begin
            it.action   = slnt_pkg::ACT_READ;
            it.position = choose_position();
        end
        else if (pick < 85)
        begin
            it.action   = slnt_pkg::ACT_DELETE;
            it.position = choose_position();
        end
        else if (pick < 86)
        begin
            it.action = slnt_pkg::ACT_CLEAR;
        end
        else if (pick < 90)
        begin
            it.action = slnt_pkg::ACTION_W'($urandom_range(7, 5));
        end
        else
        begin
            it.action = slnt_pkg::ACTION_W'($urandom_range(7));
        end
        return it;
    endfunction

    task automatic send_action(slnt_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, it.position, it.payload, it.key, it.action};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        awaited_replies.push_back(apply_to_table(it));
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (awaited_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic test_empty_table();
        send_action(make_item(slnt_pkg::ACT_FIND, 16'd1, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'hFFFF, 16'hFFFF, 8'd255));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'd0, 16'hFFFF, 8'd0));
        send_action(make_item(slnt_pkg::ACT_FIND, 16'd0, 16'd0, 8'd0));
        send_action(make_item(3'd5, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_action(make_item(3'd6, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_action(make_item(3'd7, 16'hFFFF, 16'hFFFF, 8'hFF));
        send_action(make_item(slnt_pkg::ACT_CLEAR, 16'hFFFF, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_ordering();
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'hFFFF, 16'h0000, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'h0001, 16'hFFFF, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'h8000, 16'h1234, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'h8000, 16'h5678, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'h0000, 16'h1111, 8'd0));
        send_action(make_item(slnt_pkg::ACT_FIND, 16'hFFFF, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_FIND, 16'h7FFF, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_FIND, 16'h0000, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd2));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd3));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd1));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd1));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd255));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd0));
    endtask

    task automatic test_full_table();
        logic [slnt_pkg::KEY_W-1:0] k;
        send_action(make_item(slnt_pkg::ACT_CLEAR, 16'd0, 16'd0, 8'd0));
        while (used < slnt_pkg::TABLE_DEPTH)
            send_action(make_item(slnt_pkg::ACT_ENTER,
                                  slnt_pkg::KEY_W'($urandom_range(65535, 1)),
                                  slnt_pkg::PAYLOAD_W'($urandom_range(65535)), 8'd0));
        k = absent_key();
        send_action(make_item(slnt_pkg::ACT_ENTER, k, 16'hABCD, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER,
                              tab_key[$urandom_range(slnt_pkg::TABLE_DEPTH - 1)],
                              16'h4321, 8'd0));
        send_action(make_item(slnt_pkg::ACT_ENTER, 16'd0, 16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd255));
        send_action(make_item(slnt_pkg::ACT_FIND, tab_key[slnt_pkg::TABLE_DEPTH-1],
                              16'd0, 8'd0));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd255));
        send_action(make_item(slnt_pkg::ACT_READ, 16'd0, 16'd0, 8'd255));
        send_action(make_item(slnt_pkg::ACT_ENTER, absent_key(), 16'h0F0F, 8'd0));
        send_action(make_item(slnt_pkg::ACT_DELETE, 16'd0, 16'd0, 8'd0));
    endtask

    task automatic test_random(int count);
        repeat (count)
            send_action(random_item());
    endtask

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        slnt_pkg::res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (awaited_replies.size() == 0)
            begin
                $error("result item with none expected: %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                compare_field("status", want.status, m_tdata[3:0]);
                compare_field("index", want.index, m_tdata[11:4]);
                compare_field("key_out", want.key_out, m_tdata[27:12]);
                compare_field("payload_out", want.payload_out, m_tdata[43:28]);
                compare_field("entry_count", want.entry_count, m_tdata[52:44]);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 6;
        recv_idle_pct = 85;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_empty_table();
        test_ordering();
        test_random(130);
        wait_all_results();

        send_idle_pct = 85;
        recv_idle_pct = 6;
        test_random(130);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_full_table();
        test_random(130);

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/slnt_pkg.sv
design/slnt_ram.sv
design/slnt_ctrl.sv
design/sorted_line_number_table_core.sv
bench/sorted_line_number_table_core_test.sv
